>>> sv/md5_pkg.sv
package md5_pkg;

    typedef logic [31:0] word_t;

    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hefcdab89;
    localparam word_t IV2 = 32'h98badcfe;
    localparam word_t IV3 = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Additive constant of each round
    function automatic word_t round_const(input logic [5:0] i);
        word_t k;
        begin
            case (i)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    // Left rotate amount of each round
    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word used by each round
    function automatic logic [3:0] word_sel(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0:    g = i[3:0];
                2'd1:    g = 4'((i[3:0] << 2) + i[3:0] + 4'd1);
                2'd2:    g = 4'((i[3:0] << 1) + i[3:0] + 4'd5);
                default: g = 4'((i[3:0] << 3) - i[3:0]);
            endcase
            return g;
        end
    endfunction

    // Nonlinear round function
    function automatic word_t round_func(input logic [1:0] r, input word_t b,
                                         input word_t c, input word_t d);
        word_t f;
        begin
            case (r)
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (d & b) | (~d & c);
                2'd2:    f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            return f;
        end
    endfunction

endpackage

>>> sv/md5_ram.sv
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/md5_message_digest.sv
// MD5 digest engine, one message byte per input word.
//
// Input channel (in_valid/in_ready): data_byte joins the message when
// byte_valid is set; message_end closes the message. A word with neither
// flag changes nothing. An end word without a byte finishes what is held,
// so a lone end word gives the digest of the empty message.
// Output channel (out_valid/out_ready): four digest words, word_index 0..3,
// last_word on the fourth. Bytes of the digest are little-endian per word.
//
// Flow: in_ready stays high from byte to byte; the 64th byte of a block
// starts the compression, which runs on one shared round unit: a setup
// step, 64 rounds that each form the sum and then the rotated add, and
// the chaining add. Padding writes up to 16 buffer words, one per cycle,
// then one or two compressions, then the four digest words go out, one
// per cycle while out_ready is high. in_ready is low for all of this time.
// A stalled receiver simply holds the digest word; nothing is lost.
// Reset loads the initial chaining words and clears the bit count; after
// the last digest word is taken the block does the same on its own.
module md5_message_digest (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         byte_valid,
    input  logic         message_end,
    output logic         out_valid,
    input  logic         out_ready,
    output md5_pkg::word_t digest_word,
    output logic [1:0]   word_index,
    output logic         last_word
);
    import md5_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD0  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_PRE   = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    word_t       ch_reg [4];
    word_t       ch_next [4];
    logic [63:0] count_reg, count_next;
    word_t       part_reg, part_next;       // word being assembled
    word_t       a_reg, b_reg, c_reg, d_reg;
    word_t       a_next, b_next, c_next, d_next;
    word_t       t_reg, t_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        phase_reg, phase_next;
    logic [3:0]  pw_reg, pw_next;           // padding word pointer
    logic        end_reg, end_next;
    logic        padding_reg, padding_next;
    logic        two_reg, two_next;         // padding needs a second block
    logic [1:0]  idx_reg, idx_next;

    logic        in_fire, out_fire;
    logic [5:0]  pos;
    word_t       assembled, pad_word, fill_word;
    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    word_t       ram_wdata, ram_rdata;
    logic [5:0]  rd_round;
    logic [63:0] rot_wide;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign digest_word = ch_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);

    assign pos = count_reg[8:3];

    // Insert the incoming byte into its lane; pad the partial word
    always_comb
    begin
        assembled = part_reg;
        pad_word  = '0;
        for (int l = 0; l < 4; l++)
        begin
            if (pos[1:0] == 2'(l))
            begin
                assembled[8*l +: 8] = data_byte;
                pad_word[8*l +: 8]  = PAD_BYTE;
            end
            else if (2'(l) < pos[1:0])
            begin
                pad_word[8*l +: 8] = part_reg[8*l +: 8];
            end
        end
    end

    always_comb
    begin
        fill_word = '0;
        if (!two_reg && pw_reg == 4'd14)
        begin
            fill_word = count_reg[31:0];
        end
        else if (!two_reg && pw_reg == 4'd15)
        begin
            fill_word = count_reg[63:32];
        end
    end

    // Read one round ahead so the word is ready at phase 0
    assign rd_round  = phase_reg ? 6'(rnd_reg + 6'd1) : rnd_reg;
    assign ram_raddr = word_sel(rd_round);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos[5:2];
        ram_wdata = assembled;
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = in_fire && byte_valid && (pos[1:0] == 2'd3);
            end
            ST_PAD0:
            begin
                ram_we    = 1'b1;
                ram_wdata = pad_word;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = pw_reg;
                ram_wdata = fill_word;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    md5_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_buf (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rot_wide = {t_reg, t_reg} << rot_amount(rnd_reg);

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        count_next   = count_reg;
        part_next    = part_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        t_next       = t_reg;
        rnd_next     = rnd_reg;
        phase_next   = phase_reg;
        pw_next      = pw_reg;
        end_next     = end_reg;
        padding_next = padding_reg;
        two_next     = two_reg;
        idx_next     = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    end_next     = message_end;
                    padding_next = 1'b0;
                    if (byte_valid)
                    begin
                        part_next  = assembled;
                        count_next = count_reg + 64'd8;
                    end
                    if (byte_valid && pos == 6'd63)
                    begin
                        state_next = ST_PRE;
                    end
                    else if (message_end)
                    begin
                        state_next = ST_PAD0;
                    end
                end
            end
            ST_PAD0:
            begin
                padding_next = 1'b1;
                two_next     = (pos >= 6'd56);
                pw_next      = 4'(pos[5:2] + 4'd1);
                state_next   = (pos[5:2] == 4'd15) ? ST_PRE : ST_FILL;
            end
            ST_FILL:
            begin
                pw_next = 4'(pw_reg + 4'd1);
                if (pw_reg == 4'd15)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                a_next     = ch_reg[0];
                b_next     = ch_reg[1];
                c_next     = ch_reg[2];
                d_next     = ch_reg[3];
                rnd_next   = '0;
                phase_next = 1'b0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    t_next = a_reg + round_func(rnd_reg[5:4], b_reg, c_reg, d_reg)
                           + round_const(rnd_reg) + ram_rdata;
                end
                else
                begin
                    a_next   = d_reg;
                    d_next   = c_reg;
                    c_next   = b_reg;
                    b_next   = b_reg + rot_wide[63:32];
                    rnd_next = 6'(rnd_reg + 6'd1);
                    if (rnd_reg == 6'd63)
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                ch_next[0] = ch_reg[0] + a_reg;
                ch_next[1] = ch_reg[1] + b_reg;
                ch_next[2] = ch_reg[2] + c_reg;
                ch_next[3] = ch_reg[3] + d_reg;
                if (!end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!padding_reg)
                begin
                    state_next = ST_PAD0;
                end
                else if (two_reg)
                begin
                    two_next   = 1'b0;
                    pw_next    = '0;
                    state_next = ST_FILL;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = 2'(idx_reg + 2'd1);
                    if (idx_reg == 2'd3)
                    begin
                        ch_next[0] = IV0;
                        ch_next[1] = IV1;
                        ch_next[2] = IV2;
                        ch_next[3] = IV3;
                        count_next = '0;
                        end_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ch_reg[0]   <= IV0;
            ch_reg[1]   <= IV1;
            ch_reg[2]   <= IV2;
            ch_reg[3]   <= IV3;
            count_reg   <= '0;
            rnd_reg     <= '0;
            phase_reg   <= 1'b0;
            pw_reg      <= '0;
            end_reg     <= 1'b0;
            padding_reg <= 1'b0;
            two_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            count_reg   <= count_next;
            rnd_reg     <= rnd_next;
            phase_reg   <= phase_next;
            pw_reg      <= pw_next;
            end_reg     <= end_next;
            padding_reg <= padding_next;
            two_reg     <= two_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        t_reg    <= t_next;
    end

    // Never take input while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while digest pending");

    // An end word always leads into padding or compression
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && message_end |=> !in_ready)
        else $error("end word did not start finishing");

    // The last round hands over to the chaining add
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && phase_reg && rnd_reg == 6'd63 |=> state_reg == ST_ADD)
        else $error("round sequence did not finish");

    // After the final digest word the message state restarts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && last_word |=> in_ready && count_reg == 64'd0 && ch_reg[0] == IV0)
        else $error("message state not restarted");

endmodule
